// ----- rtl/rsb_pkg.sv -----
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and constants for the run-length sprite blitter.
// ----------------------------------------------------------------------------
package rsb_pkg;

    // Frame address and sprite column widths
    localparam int ADDRESS_BITS = 24;
    localparam int WIDTH_BITS   = 16;
    localparam int ADDR_W       = ADDRESS_BITS;
    localparam int COL_W        = WIDTH_BITS + 1;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int FRAME_W     = 23;
    localparam int PITCH_W     = 16;

    // Queue between the classifier and the position engine
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Special code bytes of the sprite stream
    localparam logic [7:0] CODE_ESCAPE  = 8'd255;
    localparam logic [7:0] CODE_END_ROW = 8'd254;
    localparam logic [7:0] CODE_SKIP    = 8'd253;

    // Hue/value saturation limits
    localparam logic [7:0] NIB_MAX   = 8'h0f;
    localparam logic [7:0] SAT_LIMIT = 8'h1f;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_OFFSET = 3'd0,
        REG_FRAME_BYTES  = 3'd1,
        REG_ROW_PITCH    = 3'd2,
        REG_SPRITE_WIDTH = 3'd3,
        REG_DRAW_MODE    = 3'd4,
        REG_HUE          = 3'd5,
        REG_VALUE_OFFSET = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_COPY     = 3'd0,
        MODE_BLEND    = 3'd1,
        MODE_HV_RAW   = 3'd2,
        MODE_HV_SAT   = 3'd3,
        MODE_HV_BLEND = 3'd4,
        MODE_DARKEN   = 3'd5,
        MODE_BLACK    = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DRAW    = 2'd0,
        KIND_ESCAPE  = 2'd1,
        KIND_END_ROW = 2'd2,
        KIND_SKIP    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0]  start_offset;
        logic [FRAME_W-1:0] frame_bytes;
        logic [PITCH_W-1:0] row_pitch;
        logic [WIDTH_BITS-1:0] sprite_width;
        logic [2:0]         draw_mode;
        logic [3:0]         hue;
        logic [7:0]         value_offset;
    } t_cfg;

    // One classified item as it waits in the queue
    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
        logic [7:0] pixel;
        logic       last;
    } t_item;

    typedef struct packed {
        logic               not_empty;
        logic               full;
        logic [Q_CNT_W-1:0] level;
    } t_q_stat;

endpackage

// ----- rtl/rle_sprite_blitter_unit.sv -----
// ----------------------------------------------------------------------------
// rle_sprite_blitter_unit
// Run-length sprite decoder that turns code bytes into frame pixel writes.
//
//  Port group   Dir  Payload
//  s_axis       in   tdata[7:0] sprite_byte, tdata[15:8] dest_pixel,
//                    tlast last_byte
//  m_axis       out  tdata[23:0] write_address, [31:24] write_pixel,
//                    [55:32] next_address; tuser[0] write_enable, [1] halted
//  i_cfg        in   i_cfg_index register number, i_cfg_data value
//
// One item per cycle is sustained while m_axis_tready stays high; the position
// and column update of the back engine is a registered loop and sets that rate.
// A result leaves through a queue entry and then the output register.
// Reset is synchronous and active low. Input and output stall independently:
// the two-entry queue absorbs an output stall before input ready drops.
// ----------------------------------------------------------------------------
module rle_sprite_blitter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [rsb_pkg::IN_TDATA_W-1:0]        s_axis_tdata,   // sprite_byte, dest_pixel
    input  logic                                  s_axis_tlast,   // last_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [rsb_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // write_address, write_pixel, next_address
    output logic [rsb_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,   // write_enable, halted
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rsb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rsb_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import rsb_pkg::*;

    t_cfg    r_cfg;
    t_item   push_item;
    t_item   head_item;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    logic    cfg_wr;
    logic    restart;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_wr && (t_cfg_idx'(i_cfg_index) == REG_START_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_offset <= '0;
            r_cfg.frame_bytes  <= '0;
            r_cfg.row_pitch    <= PITCH_W'(320);
            r_cfg.sprite_width <= WIDTH_BITS'(1);
            r_cfg.draw_mode    <= MODE_COPY;
            r_cfg.hue          <= '0;
            r_cfg.value_offset <= '0;
        end else if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_START_OFFSET: r_cfg.start_offset <= i_cfg_data[ADDR_W-1:0];
                REG_FRAME_BYTES:  r_cfg.frame_bytes  <= i_cfg_data[FRAME_W-1:0];
                REG_ROW_PITCH:    r_cfg.row_pitch    <= i_cfg_data[PITCH_W-1:0];
                REG_SPRITE_WIDTH: r_cfg.sprite_width <= i_cfg_data[WIDTH_BITS-1:0];
                REG_DRAW_MODE:    r_cfg.draw_mode    <= i_cfg_data[2:0];
                REG_HUE:          r_cfg.hue          <= i_cfg_data[3:0];
                REG_VALUE_OFFSET: r_cfg.value_offset <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    rsb_front u_front (
        .i_cfg         (r_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_item        (push_item)
    );

    rsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    rsb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_restart     (restart),
        .i_restart_pos (i_cfg_data[ADDR_W-1:0]),
        .i_q_stat      (q_stat),
        .i_item        (head_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // A halted result never carries a write.
    a_halt_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("write reported together with halt");

    // Writes land inside the frame: never below offset zero, never at the limit.
    a_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            !m_axis_tdata[ADDR_W-1] &&
            (m_axis_tdata[ADDR_W-1:0] < {1'b0, r_cfg.frame_bytes}))
        else $error("write address outside frame");

    // The queue never overfills and never pops while empty.
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.level <= Q_CNT_W'(Q_DEPTH)) && !(pop && !q_stat.not_empty))
        else $error("queue level out of range");

    // An accepted item is handed to the queue in the same cycle.
    a_accept_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> push && !q_stat.full)
        else $error("accepted item not queued");

endmodule

// ----- rtl/rsb_front.sv -----
// ----------------------------------------------------------------------------
// rsb_front
// Accepts sprite bytes, classifies the code and shades the candidate pixel.
// ----------------------------------------------------------------------------
module rsb_front (
    input  rsb_pkg::t_cfg                         i_cfg,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [rsb_pkg::IN_TDATA_W-1:0]        s_axis_tdata,   // sprite_byte, dest_pixel
    input  logic                                  s_axis_tlast,   // last_byte
    input  rsb_pkg::t_q_stat                      i_q_stat,
    output logic                                  o_push,
    output rsb_pkg::t_item                        o_item
);
    import rsb_pkg::*;

    logic [7:0] code;
    logic [7:0] dest;
    logic [7:0] hv_raw;
    logic [3:0] hv_sat;
    logic [4:0] blend_sum;
    logic [4:0] hv_sum;
    logic [7:0] shade;

    assign code = s_axis_tdata[7:0];
    assign dest = s_axis_tdata[15:8];

    assign s_axis_tready = !i_q_stat.full;
    assign o_push        = s_axis_tvalid && !i_q_stat.full;

    // Brightness offset on the low nibble, kept modulo 256
    assign hv_raw = {4'd0, code[3:0]} + i_cfg.value_offset;

    always_comb begin
        if (hv_raw > NIB_MAX) begin
            hv_sat = (hv_raw >= SAT_LIMIT) ? 4'd0 : 4'hf;
        end else begin
            hv_sat = hv_raw[3:0];
        end
    end

    assign blend_sum = {1'b0, dest[3:0]} + {1'b0, code[3:0]};
    assign hv_sum    = {1'b0, dest[3:0]} + {1'b0, hv_sat};

    always_comb begin
        case (t_mode'(i_cfg.draw_mode))
            MODE_BLEND:    shade = {code[7:4], blend_sum[4:1]};
            MODE_HV_RAW:   shade = {i_cfg.hue, 4'd0} | hv_raw;
            MODE_HV_SAT:   shade = {i_cfg.hue, hv_sat};
            MODE_HV_BLEND: shade = {i_cfg.hue, hv_sum[4:1]};
            MODE_DARKEN:   shade = {dest[7:4], 1'b0, dest[3:1]};
            MODE_BLACK:    shade = 8'd0;
            default:       shade = code;
        endcase
    end

    always_comb begin
        o_item.code  = code;
        o_item.pixel = shade;
        o_item.last  = s_axis_tlast;
        case (code)
            CODE_ESCAPE:  o_item.kind = KIND_ESCAPE;
            CODE_END_ROW: o_item.kind = KIND_END_ROW;
            CODE_SKIP:    o_item.kind = KIND_SKIP;
            default:      o_item.kind = KIND_DRAW;
        endcase
    end

endmodule

// ----- rtl/rsb_queue.sv -----
// ----------------------------------------------------------------------------
// rsb_queue
// Two-entry register queue between the classifier and the position engine.
// ----------------------------------------------------------------------------
module rsb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rsb_pkg::t_item    i_item,
    input  logic              i_pop,
    output rsb_pkg::t_item    o_item,
    output rsb_pkg::t_q_stat  o_stat
);
    import rsb_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.level     = r_count;

endmodule

// ----- rtl/rsb_back.sv -----
// ----------------------------------------------------------------------------
// rsb_back
// Position engine: tracks frame position and column, decides each write and
// holds the result item in an output register.
// ----------------------------------------------------------------------------
module rsb_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rsb_pkg::t_cfg                         i_cfg,
    input  logic                                  i_restart,
    input  logic [rsb_pkg::ADDR_W-1:0]            i_restart_pos,
    input  rsb_pkg::t_q_stat                      i_q_stat,
    input  rsb_pkg::t_item                        i_item,
    output logic                                  o_pop,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [rsb_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // write_address, write_pixel, next_address
    output logic [rsb_pkg::OUT_TUSER_W-1:0]       m_axis_tuser   // write_enable, halted
);
    import rsb_pkg::*;

    logic [ADDR_W-1:0] r_pos;
    logic [COL_W-1:0]  r_col;
    logic              r_expect;
    logic              r_stopped;

    logic [ADDR_W-1:0] n_pos;
    logic [COL_W-1:0]  n_col;
    logic              n_expect;
    logic              n_stopped;

    logic              r_out_valid;
    logic              r_out_we;
    logic              r_out_halted;
    logic [ADDR_W-1:0] r_out_waddr;
    logic [7:0]        r_out_pixel;
    logic [ADDR_W-1:0] r_out_next;

    logic              we;
    logic [7:0]        wpix;
    logic              halted;
    logic              end_row;
    logic [7:0]        adv;
    logic [COL_W-1:0]  col_sum;
    logic              at_limit;

    assign o_pop    = i_q_stat.not_empty && (!r_out_valid || m_axis_tready);
    assign at_limit = $signed(r_pos) >= $signed({1'b0, i_cfg.frame_bytes});
    assign col_sum  = r_col + COL_W'(adv);

    always_comb begin
        n_pos     = r_pos;
        n_col     = r_col;
        n_expect  = r_expect;
        n_stopped = r_stopped;
        we        = 1'b0;
        wpix      = 8'd0;
        end_row   = 1'b0;
        adv       = 8'd0;
        if (!r_stopped) begin
            if (r_expect) begin
                // Byte after an escape is a transparent skip count
                n_expect = 1'b0;
                adv      = i_item.code;
            end else begin
                case (i_item.kind)
                    KIND_ESCAPE:  n_expect = 1'b1;
                    KIND_END_ROW: end_row  = 1'b1;
                    KIND_SKIP:    adv      = 8'd1;
                    default: begin
                        if (at_limit) begin
                            n_stopped = 1'b1;
                        end else begin
                            if (!r_pos[ADDR_W-1]) begin
                                we   = 1'b1;
                                wpix = i_item.pixel;
                            end
                            adv = 8'd1;
                        end
                    end
                endcase
            end
            // Row wrap drops the advance and moves to the row start plus the pitch.
            if (!n_stopped && (end_row || col_sum >= {1'b0, i_cfg.sprite_width})) begin
                n_pos = r_pos + ADDR_W'(i_cfg.row_pitch) - ADDR_W'(r_col);
                n_col = '0;
            end else begin
                n_pos = r_pos + ADDR_W'(adv);
                n_col = col_sum;
            end
        end
        halted = n_stopped;
        if (i_item.last) begin
            n_pos     = i_cfg.start_offset;
            n_col     = '0;
            n_expect  = 1'b0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_col       <= '0;
            r_expect    <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_restart) begin
                r_pos     <= i_restart_pos;
                r_col     <= '0;
                r_expect  <= 1'b0;
                r_stopped <= 1'b0;
            end else if (o_pop) begin
                r_pos     <= n_pos;
                r_col     <= n_col;
                r_expect  <= n_expect;
                r_stopped <= n_stopped;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_we     <= we;
            r_out_halted <= halted;
            r_out_waddr  <= we ? r_pos : '0;
            r_out_pixel  <= wpix;
            r_out_next   <= n_pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_next, r_out_pixel, r_out_waddr};
    assign m_axis_tuser  = {r_out_halted, r_out_we};

endmodule
